>>> rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Types and constants shared by the shutter and T0 timestamp tracker.
// ----------------------------------------------------------------------------
package stt_pkg;

	// Time in nanoseconds, saturated to 52 bits.
	localparam int TIME_W = 52;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// Field positions inside a timestamp word.
	localparam int LEV_LSB = 48;
	localparam int TRG_LSB = 56;
	localparam int SIG_T0 = 0;
	localparam int SIG_SHUTTER = 2;

	// Frame status codes.
	localparam int STATUS_W = 3;
	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DROP    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOSHUT  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_T0FIRST = 3'd3;
	localparam logic [STATUS_W-1:0] ST_T0AGAIN = 3'd4;

	// Configuration register map.
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 10;
	localparam int WIN_W = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_DROP_BEFORE_T0 = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_T0_WINDOW = 4'd1;
	localparam logic [WIN_W-1:0] T0_WINDOW_RESET = 10'd10;

	// T0 event counter saturates at two.
	localparam logic [1:0] T0_EVENTS_MAX = 2'd2;

	// Input transaction payload.
	typedef struct packed {
		logic [63:0] timestamp_word;
		logic        frame_last;
	} stt_in_t;

	// Output transaction payload.
	typedef struct packed {
		logic [STATUS_W-1:0] frame_status;
		logic [TIME_W-1:0]   window_open_ns;
		logic [TIME_W-1:0]   window_close_ns;
	} stt_out_t;

	// A classified word as it travels from the front to the back.
	typedef struct packed {
		logic [TIME_W-1:0] time_ns;
		logic              last;
		logic              legacy;
		logic              shutter_high;
		logic              t0_high;
		logic              shutter_trig;
		logic              t0_direct;
	} stt_item_t;

endpackage

>>> rtl/shutter_and_t0_timestamp_tracker_core.sv
// ----------------------------------------------------------------------------
// shutter_and_t0_timestamp_tracker_core
// Tracks shutter times and T0 events over frames of timestamp words.
// ----------------------------------------------------------------------------
// Usage:
// Timestamp words enter on the input channel (in_valid, in_stall, in_data),
// one word per cycle; frame_last marks the final word of a frame. For every
// frame one result leaves on the output channel (out_valid, out_stall,
// out_data) with the frame status and the shutter open and close times.
// The two configuration registers are written through cfg_valid/cfg_ready,
// cfg_index and cfg_data; the user must write them only while no frame is
// in flight, as the block does not enforce this. cfg_ready is always high.
// The result is offered from the output register once the frame's last word
// has passed through the scaling stage and the queue to the back end.
// Throughput is one word per cycle unless stalled, set by the back end, which
// updates the frame state once per word. A four-entry queue sits between the
// front (tick scaling and classification) and the back; in_stall rises when
// the queue and the scaling stage together hold a full queue's worth.
// When out_stall holds a result, words still flow until a further frame end
// reaches the back, then the queue fills and in_stall rises.
// Reset clears all tracker state, sets drop_before_first_t0 to one and the
// T0 window to 10 ns, and leaves both channels idle.
// ----------------------------------------------------------------------------
module shutter_and_t0_timestamp_tracker_core import stt_pkg::*; #(
	parameter int TICK_NS = 10,
	parameter int TICK_BITS = 48,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  stt_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output stt_out_t              out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic             drop_early_q;
	logic [WIN_W-1:0] t0_window_q;
	logic             push;
	stt_item_t        push_item;
	logic             pop;
	logic             head_valid;
	stt_item_t        head;
	logic [CNT_W-1:0] q_count;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_early_q <= 1'b1;
			t0_window_q  <= T0_WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DROP_BEFORE_T0: drop_early_q <= cfg_data[0];
				CFG_T0_WINDOW:      t0_window_q <= cfg_data[WIN_W-1:0];
				default:            ;
			endcase
		end
	end

	// Front end: scaling and classification.
	stt_front #(
		.TICK_NS     (TICK_NS),
		.TICK_BITS   (TICK_BITS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.window_ns (t0_window_q),
		.q_count   (q_count),
		.push      (push),
		.push_item (push_item)
	);

	// Queue between the two halves.
	stt_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.count      (q_count)
	);

	// Back end: frame state and results.
	stt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.drop_early_en (drop_early_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data)
	);

endmodule

>>> rtl/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front
// Accepts timestamp words, scales ticks to nanoseconds and classifies them.
// ----------------------------------------------------------------------------
module stt_front import stt_pkg::*; #(
	parameter int TICK_NS = 10,
	parameter int TICK_BITS = 48,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  stt_in_t                            in_data,
	input  logic [WIN_W-1:0]                   window_ns,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count,
	output logic                               push,
	output stt_item_t                          push_item
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int NS_W = $clog2(TICK_NS + 1);
	localparam int PROD_W = TICK_BITS + NS_W;
	localparam int CMP_W = (PROD_W > TIME_W) ? PROD_W : TIME_W + 1;
	localparam logic [NS_W-1:0] TICK_NS_C = NS_W'(TICK_NS);

	logic              accept;
	logic [CNT_W:0]    in_flight;
	logic              valid_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [7:0]        trg_s1;
	logic [7:0]        lev_s1;
	logic              last_s1;
	logic [CMP_W-1:0]  prod_ext;
	logic [TIME_W-1:0] time_ns;

	// Items in the stage and the queue must always fit the queue, so the
	// stage can push without looking back.
	assign in_flight = {1'b0, q_count} + {{CNT_W{1'b0}}, valid_s1};
	assign in_stall = (in_flight >= (CNT_W+1)'(QUEUE_DEPTH));
	assign accept = in_valid && !in_stall;

	// Stage one: tick scaling.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1 <= PROD_W'(in_data.timestamp_word[TICK_BITS-1:0]) * PROD_W'(TICK_NS_C);
			trg_s1  <= in_data.timestamp_word[TRG_LSB +: 8];
			lev_s1  <= in_data.timestamp_word[LEV_LSB +: 8];
			last_s1 <= in_data.frame_last;
		end
	end

	// Saturate the time and classify the word.
	assign prod_ext = CMP_W'(prod_s1);
	assign time_ns = (prod_ext > CMP_W'(TIME_MAX)) ? TIME_MAX : prod_ext[TIME_W-1:0];

	always_comb begin
		push = valid_s1;
		push_item.time_ns      = time_ns;
		push_item.last         = last_s1;
		push_item.legacy       = (trg_s1 == 8'd0);
		push_item.shutter_high = lev_s1[SIG_SHUTTER];
		push_item.t0_high      = lev_s1[SIG_T0];
		push_item.shutter_trig = trg_s1[SIG_SHUTTER];
		push_item.t0_direct    = trg_s1[SIG_T0] && !lev_s1[SIG_T0]
			&& (time_ns <= TIME_W'(window_ns));
	end

endmodule

>>> rtl/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
module stt_queue import stt_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  stt_item_t                          push_item,
	input  logic                               pop,
	output logic                               head_valid,
	output stt_item_t                          head,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	stt_item_t        slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head_valid = (count_q != '0);
	assign head = slot_q[rd_ptr_q];
	assign count = count_q;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> rtl/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back
// Applies each word to the frame state and issues the frame result.
// ----------------------------------------------------------------------------
module stt_back import stt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  stt_item_t head,
	output logic      pop,
	input  logic      drop_early_en,
	output logic      out_valid,
	input  logic      out_stall,
	output stt_out_t  out_data
);

	logic              window_open_q;
	logic              full_window_q;
	logic [TIME_W-1:0] open_time_q;
	logic [TIME_W-1:0] close_time_q;
	logic              aborted_q;
	logic [STATUS_W-1:0] abort_code_q;
	logic              t0_level_q;
	logic [1:0]        t0_events_q;
	logic [TIME_W-1:0] prev_open_q;
	logic              out_valid_q;
	stt_out_t          out_data_q;

	logic              window_open_d;
	logic              full_window_d;
	logic [TIME_W-1:0] open_time_d;
	logic [TIME_W-1:0] close_time_d;
	logic              aborted_d;
	logic [STATUS_W-1:0] abort_code_d;
	logic              t0_level_d;
	logic [1:0]        t0_events_d;
	logic [TIME_W-1:0] prev_open_d;
	logic [1:0]        events_inc;
	logic [STATUS_W-1:0] event_status;
	logic              do_open;
	logic              do_close;
	logic              t0_fire;
	logic              out_free;
	stt_out_t          result;

	// A closing word may only be taken when the output register is free.
	assign out_free = !out_valid_q || !out_stall;
	assign pop = head_valid && (!head.last || out_free);

	// Saturating T0 count and the status that a new event gives.
	assign events_inc = (t0_events_q < T0_EVENTS_MAX) ? t0_events_q + 2'd1 : T0_EVENTS_MAX;
	assign event_status = (events_inc == 2'd1) ? ST_T0FIRST : ST_T0AGAIN;

	// Word scan and end-of-frame decision.
	always_comb begin
		do_open  = 1'b0;
		do_close = 1'b0;
		t0_fire  = 1'b0;
		t0_level_d = t0_level_q;
		if (!aborted_q) begin
			if (head.legacy) begin
				do_open  = head.shutter_high;
				do_close = !head.shutter_high && window_open_q;
				if (head.t0_high) begin
					t0_level_d = 1'b1;
				end else if (t0_level_q) begin
					t0_level_d = 1'b0;
					t0_fire = 1'b1;
				end
			end else begin
				do_open  = head.shutter_trig && head.shutter_high;
				do_close = head.shutter_trig && !head.shutter_high && window_open_q;
				t0_fire  = head.t0_direct;
			end
		end

		open_time_d   = do_open ? head.time_ns : open_time_q;
		close_time_d  = do_close ? head.time_ns : close_time_q;
		window_open_d = do_open ? 1'b1 : (do_close ? 1'b0 : window_open_q);
		full_window_d = full_window_q || do_close;
		aborted_d     = aborted_q || t0_fire;
		abort_code_d  = t0_fire ? event_status : abort_code_q;
		t0_events_d   = t0_fire ? events_inc : t0_events_q;
		prev_open_d   = prev_open_q;

		result.frame_status    = ST_OK;
		result.window_open_ns  = '0;
		result.window_close_ns = '0;

		if (head.last) begin
			if (aborted_d) begin
				result.frame_status = abort_code_d;
			end else if (!full_window_d) begin
				result.frame_status = ST_NOSHUT;
			end else if ((open_time_d > close_time_d) || (prev_open_q > open_time_d)) begin
				// Shutter times out of order count as a T0 event.
				result.frame_status = event_status;
				t0_events_d = events_inc;
			end else begin
				prev_open_d = open_time_d;
				result.frame_status = (drop_early_en && (t0_events_q == 2'd0))
					? ST_DROP : ST_OK;
				result.window_open_ns  = open_time_d;
				result.window_close_ns = close_time_d;
			end
			// Per-frame state starts afresh.
			window_open_d = 1'b0;
			full_window_d = 1'b0;
			open_time_d   = '0;
			close_time_d  = '0;
			aborted_d     = 1'b0;
		end
	end

	// Tracker state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_open_q <= 1'b0;
			full_window_q <= 1'b0;
			open_time_q   <= '0;
			close_time_q  <= '0;
			aborted_q     <= 1'b0;
			abort_code_q  <= ST_OK;
			t0_level_q    <= 1'b0;
			t0_events_q   <= 2'd0;
			prev_open_q   <= '0;
		end else if (pop) begin
			window_open_q <= window_open_d;
			full_window_q <= full_window_d;
			open_time_q   <= open_time_d;
			close_time_q  <= close_time_d;
			aborted_q     <= aborted_d;
			abort_code_q  <= abort_code_d;
			t0_level_q    <= t0_level_d;
			t0_events_q   <= t0_events_d;
			prev_open_q   <= prev_open_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

`ifndef SYNTHESIS
	// Rejected or T0 frames carry no times.
	a_times_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_data_q.frame_status != ST_OK)
			&& (out_data_q.frame_status != ST_DROP)
		|-> (out_data_q.window_open_ns == '0) && (out_data_q.window_close_ns == '0))
		else $error("times set on a rejected frame");

	// A good frame never closes before it opens.
	a_ordered_times: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ((out_data_q.frame_status == ST_OK)
			|| (out_data_q.frame_status == ST_DROP))
		|-> (out_data_q.window_open_ns <= out_data_q.window_close_ns))
		else $error("good frame with open after close");

	// The T0 count only grows and stays at its ceiling.
	a_events_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (t0_events_q >= $past(t0_events_q)) && (t0_events_q <= T0_EVENTS_MAX))
		else $error("T0 count went back or past its ceiling");

	// A frame end is never lost while a result waits.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !(pop && head.last))
		else $error("result overwritten while stalled");
`endif

endmodule

>>> tb/stt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stt_checker
// Watches the channels of the shutter and T0 tracker and checks its reports.
// Every accepted timestamp word is run through a behavioural copy of the
// tracker; each frame end queues the report it should produce. Accepted
// reports are compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module stt_checker import stt_pkg::*; #(
	parameter int TICK_NS = 10,
	parameter int TICK_BITS = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  stt_in_t               in_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  stt_out_t              out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    reports_pending,
	output int                    reports_checked,
	output logic [4:0]            status_seen
);

	// Register copies, as last written through the configuration port.
	logic             drop_early;
	logic [WIN_W-1:0] t0_window;

	// Tracker state of the current frame and across frames.
	logic                win_open;
	logic                full_win;
	logic                aborted;
	logic                t0_held;
	logic [TIME_W-1:0]   open_ns;
	logic [TIME_W-1:0]   close_ns;
	logic [TIME_W-1:0]   last_open_ns;
	logic [STATUS_W-1:0] abort_status;
	logic [1:0]          t0_count;

	// Reports still owed by the block, oldest first.
	stt_out_t frame_reports[$];
	stt_out_t want;

	// Clears what belongs to a single frame.
	function automatic void clear_frame();
		win_open = 1'b0;
		full_win = 1'b0;
		open_ns = '0;
		close_ns = '0;
		aborted = 1'b0;
	endfunction

	// Counts a T0 event, saturating at two, and gives the status it implies.
	function automatic logic [STATUS_W-1:0] count_t0();
		if (t0_count != T0_EVENTS_MAX)
			t0_count = t0_count + 2'd1;
		return (t0_count == 2'd1) ? ST_T0FIRST : ST_T0AGAIN;
	endfunction

	// Advances the tracker by one word and queues a report at a frame end.
	function automatic void track_word(stt_in_t w);
		logic [7:0]        lev;
		logic [7:0]        trg;
		logic [63:0]       scaled;
		logic [TIME_W-1:0] t;
		logic              sh_hi;
		logic              t0_hi;
		stt_out_t          rep;

		lev = w.timestamp_word[LEV_LSB +: 8];
		trg = w.timestamp_word[TRG_LSB +: 8];
		scaled = (w.timestamp_word & ((64'd1 << TICK_BITS) - 64'd1)) * 64'(TICK_NS);
		t = (scaled > 64'(TIME_MAX)) ? TIME_MAX : scaled[TIME_W-1:0];
		sh_hi = lev[SIG_SHUTTER];
		t0_hi = lev[SIG_T0];

		if (!aborted) begin
			if (trg == 8'd0) begin
				// Legacy rules: levels alone drive the shutter and T0.
				if (sh_hi) begin
					open_ns = t;
					win_open = 1'b1;
				end else if (win_open) begin
					close_ns = t;
					win_open = 1'b0;
					full_win = 1'b1;
				end
				if (t0_hi)
					t0_held = 1'b1;
				else if (t0_held) begin
					t0_held = 1'b0;
					abort_status = count_t0();
					aborted = 1'b1;
				end
			end else begin
				// New rules: only triggered signals count.
				if (trg[SIG_SHUTTER] && sh_hi) begin
					open_ns = t;
					win_open = 1'b1;
				end else if (trg[SIG_SHUTTER] && win_open) begin
					close_ns = t;
					win_open = 1'b0;
					full_win = 1'b1;
				end
				if (trg[SIG_T0] && !t0_hi && t <= TIME_W'(t0_window)) begin
					abort_status = count_t0();
					aborted = 1'b1;
				end
			end
		end

		if (w.frame_last) begin
			rep = '0;
			if (aborted)
				rep.frame_status = abort_status;
			else if (!full_win)
				rep.frame_status = ST_NOSHUT;
			else if (open_ns > close_ns)
				rep.frame_status = count_t0();
			else if (last_open_ns > open_ns)
				rep.frame_status = count_t0();
			else begin
				last_open_ns = open_ns;
				rep.frame_status = (drop_early && t0_count == 2'd0) ? ST_DROP : ST_OK;
				rep.window_open_ns = open_ns;
				rep.window_close_ns = close_ns;
			end
			frame_reports = {frame_reports, rep};
			clear_frame();
		end
	endfunction

	// Reports are compared before new words are predicted, since a report can
	// never belong to a word accepted on the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_early = 1'b1;
			t0_window = T0_WINDOW_RESET;
			clear_frame();
			abort_status = '0;
			t0_held = 1'b0;
			t0_count = '0;
			last_open_ns = '0;
			frame_reports.delete();
			fail_count = 0;
			reports_pending = 0;
			reports_checked = 0;
			status_seen = '0;
		end else begin
			if (out_valid && !out_stall) begin
				reports_checked++;
				if (out_data.frame_status <= ST_T0AGAIN)
					status_seen[out_data.frame_status] = 1'b1;
				if (frame_reports.size() == 0) begin
					$display("%0t: report transaction with none expected: status %0d open %0d close %0d",
						$time, out_data.frame_status, out_data.window_open_ns,
						out_data.window_close_ns);
					fail_count++;
				end else begin
					want = frame_reports.pop_front();
					if (out_data.frame_status !== want.frame_status) begin
						$display("%0t: frame_status expected %0d, got %0d",
							$time, want.frame_status, out_data.frame_status);
						fail_count++;
					end
					if (out_data.window_open_ns !== want.window_open_ns) begin
						$display("%0t: window_open_ns expected %0d, got %0d",
							$time, want.window_open_ns, out_data.window_open_ns);
						fail_count++;
					end
					if (out_data.window_close_ns !== want.window_close_ns) begin
						$display("%0t: window_close_ns expected %0d, got %0d",
							$time, want.window_close_ns, out_data.window_close_ns);
						fail_count++;
					end
				end
			end

			// Register writes; unknown indexes are ignored by the block.
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_DROP_BEFORE_T0)
					drop_early = cfg_data[0];
				else if (cfg_index == CFG_T0_WINDOW)
					t0_window = cfg_data[WIN_W-1:0];
			end

			if (in_valid && !in_stall)
				track_word(in_data);

			reports_pending = frame_reports.size();
		end
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the shutter and T0 timestamp tracker.
// A directed set of frames covers the status codes, full-range ticks and the
// T0 counter ceiling; then random frames, mostly well-formed shutter windows
// with T0 events, flaws and noise mixed in, run under four register settings
// with random idling on both channels and one long hold on the report side.
// ----------------------------------------------------------------------------
module tb;
	import stt_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef enum {FLAW_NONE, FLAW_NO_CLOSE, FLAW_REVERSED} flaw_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	stt_in_t               in_data;
	logic                  out_valid;
	logic                  out_stall;
	stt_out_t              out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int         fail_count;
	int         reports_pending;
	int         reports_checked;
	logic [4:0] status_seen;

	// Shared between the stimulus and the report side.
	bit          steady;
	bit          hold_req;
	int          cycle_count = 0;
	int          words_sent = 0;
	int          frames_sent = 0;
	logic [47:0] tick_base;
	stt_in_t     frame_words[$];

	shutter_and_t0_timestamp_tracker_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	stt_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_data        (out_data),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.reports_pending (reports_pending),
		.reports_checked (reports_checked),
		.status_seen     (status_seen)
	);

	always #5 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Report side: random stalls, one long hold on request, none when steady.
	initial begin : report_side
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_req && !hold_done) begin
				hold_done = 1;
				hold_left = 150;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !steady && ($urandom_range(99) < 23);
			end
		end
	end

	// A byte with the shutter and T0 bits as given and the rest random.
	function automatic logic [7:0] level_byte(bit shutter, bit t0);
		logic [7:0] b;
		b = 8'($urandom);
		b[SIG_SHUTTER] = shutter;
		b[SIG_T0] = t0;
		return b;
	endfunction

	// As above but never zero, so that the new rules apply.
	function automatic logic [7:0] trig_byte(bit shutter, bit t0);
		logic [7:0] b;
		b = level_byte(shutter, t0);
		if (b == 8'd0)
			b[1] = 1'b1;
		return b;
	endfunction

	// A byte with only the shutter and T0 bits as given.
	function automatic logic [7:0] sig_byte(bit shutter, bit t0);
		logic [7:0] b;
		b = 8'd0;
		b[SIG_SHUTTER] = shutter;
		b[SIG_T0] = t0;
		return b;
	endfunction

	task automatic add_word(input logic [7:0] trg, input logic [7:0] lev,
			input logic [47:0] ticks);
		stt_in_t w;
		w.timestamp_word = {trg, lev, ticks};
		w.frame_last = 1'b0;
		frame_words = {frame_words, w};
	endtask

	// Offers one word and waits for its transaction; called at a falling edge.
	task automatic send_word(input stt_in_t w);
		while (!steady && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
		words_sent++;
		@(negedge clk);
	endtask

	// Marks the final word of the gathered frame and sends it all.
	task automatic send_frame();
		frame_words[$].frame_last = 1'b1;
		foreach (frame_words[i])
			send_word(frame_words[i]);
		frame_words.delete();
		frames_sent++;
	endtask

	// A shutter window frame on the running time base, optionally with a T0
	// event or a flaw.
	task automatic build_frame(input bit legacy, input bit with_t0, input flaw_t flaw);
		logic [47:0] open_t;
		logic [47:0] mid_t;
		logic [47:0] close_t;
		int          n;

		n = $urandom_range(0, 2);
		repeat (n)
			add_word(legacy ? 8'd0 : trig_byte(1'b0, 1'b0), level_byte(1'b0, 1'b0),
				tick_base + 48'($urandom_range(0, 4)));
		if (legacy && with_t0)
			add_word(8'd0, level_byte(1'b0, 1'b1), tick_base);

		open_t = tick_base + 48'($urandom_range(5, 30));
		add_word(legacy ? 8'd0 : trig_byte(1'b1, 1'b0), level_byte(1'b1, 1'b0), open_t);
		if (!legacy && with_t0)
			add_word(trig_byte(1'b0, 1'b1), level_byte(1'($urandom_range(1)), 1'b0),
				48'($urandom_range(0, 110)));

		// Words while open; in legacy form a held shutter level moves the open time.
		n = $urandom_range(0, 2);
		repeat (n) begin
			mid_t = open_t + 48'($urandom_range(0, 5));
			if (legacy) begin
				add_word(8'd0, level_byte(1'b1, 1'b0), mid_t);
				open_t = mid_t;
			end else begin
				add_word(trig_byte(1'b0, 1'b0), level_byte(1'($urandom_range(1)), 1'b0), mid_t);
			end
		end

		if (flaw != FLAW_NO_CLOSE) begin
			if (flaw == FLAW_REVERSED)
				close_t = open_t - 48'($urandom_range(1, 5));
			else
				close_t = open_t + 48'($urandom_range(0, 40));
			add_word(legacy ? 8'd0 : trig_byte(1'b1, 1'b0), level_byte(1'b0, 1'b0), close_t);
			if ($urandom_range(1))
				add_word(legacy ? 8'd0 : trig_byte(1'b0, 1'b0), level_byte(1'b0, 1'b0),
					open_t + 48'd60);
		end
		tick_base = open_t + 48'd64;
	endtask

	// Random frames until the given number of words has gone out.
	task automatic run_random(input int words);
		int          stop_at;
		int          pick;
		int          n;
		bit          legacy;
		logic [7:0]  w_trg;
		logic [7:0]  w_lev;

		stop_at = words_sent + words;
		while (words_sent < stop_at) begin
			pick = $urandom_range(99);
			legacy = 1'($urandom_range(1));
			if (pick < 55)
				build_frame(legacy, 1'b0, FLAW_NONE);
			else if (pick < 70)
				build_frame(legacy, 1'b1, FLAW_NONE);
			else if (pick < 80)
				build_frame(legacy, 1'b0, FLAW_NO_CLOSE);
			else if (pick < 88)
				build_frame(legacy, 1'b0, FLAW_REVERSED);
			else begin
				// Noise with full range ticks; the shutter level is kept low so no
				// window opens and the open times stay in order.
				n = $urandom_range(1, 4);
				repeat (n) begin
					w_trg = $urandom_range(1) ? 8'd0 : 8'($urandom);
					w_lev = 8'($urandom);
					w_lev[SIG_SHUTTER] = 1'b0;
					add_word(w_trg, w_lev, 48'({$urandom, $urandom}));
				end
			end
			send_frame();
		end
	endtask

	// Waits until every report has arrived and the pipeline has drained.
	task automatic settle();
		in_valid <= 1'b0;
		while (reports_pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// One register write transaction; the caller lowers cfg_valid afterwards.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	initial begin : stimulus
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady = 0;
		hold_req = 0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames under the reset settings.
		// A good window before any T0 is dropped, in both formats.
		add_word(8'd0, sig_byte(1'b1, 1'b0), 48'd100);
		add_word(8'd0, sig_byte(1'b0, 1'b0), 48'd200);
		send_frame();
		add_word(sig_byte(1'b1, 1'b0), sig_byte(1'b1, 1'b0), 48'd210);
		add_word(sig_byte(1'b1, 1'b0), sig_byte(1'b0, 1'b0), 48'd230);
		send_frame();
		// No shutter window at all.
		add_word(8'd0, sig_byte(1'b0, 1'b0), 48'd240);
		send_frame();
		// Direct T0 right at the window edge: first T0, rest of the frame ignored.
		add_word(sig_byte(1'b0, 1'b1), sig_byte(1'b0, 1'b0), 48'd1);
		add_word(8'd0, sig_byte(1'b1, 1'b0), 48'd250);
		send_frame();
		// Direct T0 with the level high and one too late are both ignored.
		add_word(sig_byte(1'b0, 1'b1), sig_byte(1'b0, 1'b1), 48'd0);
		add_word(sig_byte(1'b0, 1'b1), sig_byte(1'b0, 1'b0), 48'd2);
		add_word(8'd0, sig_byte(1'b1, 1'b0), 48'd300);
		add_word(8'd0, sig_byte(1'b0, 1'b0), 48'd310);
		send_frame();
		// Legacy falling T0 levels, repeated so the count reaches its ceiling.
		repeat (2) begin
			add_word(8'd0, sig_byte(1'b0, 1'b1), 48'd320);
			add_word(8'd0, sig_byte(1'b0, 1'b0), 48'd330);
			send_frame();
		end
		// Close before open.
		add_word(8'd0, sig_byte(1'b1, 1'b0), 48'd500);
		add_word(8'd0, sig_byte(1'b0, 1'b0), 48'd400);
		send_frame();
		// Open time earlier than the last accepted frame's.
		add_word(8'd0, sig_byte(1'b1, 1'b0), 48'd250);
		add_word(8'd0, sig_byte(1'b0, 1'b0), 48'd260);
		send_frame();
		// Close time at the largest tick count.
		add_word(8'd0, sig_byte(1'b1, 1'b0), 48'd1000);
		add_word(8'd0, 8'hfa, '1);
		send_frame();
		// All trigger and level bits set, then the T0 bits and the shutter level cleared.
		add_word(8'hff, 8'hff, 48'd1100);
		add_word(8'hfe, 8'hfa, 48'd1200);
		send_frame();
		// Largest tick count as the open time, with no close.
		add_word(8'd0, sig_byte(1'b1, 1'b0), '1);
		send_frame();

		tick_base = 48'd1300;
		run_random(200);
		settle();

		// Keep every frame, a T0 window of 1000 ns; part of it without any idling.
		write_reg(CFG_DROP_BEFORE_T0, 10'd0);
		write_reg(CFG_T0_WINDOW, 10'd1000);
		cfg_valid <= 1'b0;
		steady = 1;
		run_random(150);
		steady = 0;
		run_random(100);
		settle();

		// Drop early frames, narrowest window; the report side holds off once.
		write_reg(CFG_DROP_BEFORE_T0, 10'd1);
		write_reg(CFG_T0_WINDOW, 10'd0);
		cfg_valid <= 1'b0;
		hold_req = 1;
		run_random(200);
		settle();

		// Upper data bits are masked off and an unknown index is ignored.
		write_reg(CFG_DROP_BEFORE_T0, 10'h3fe);
		write_reg('1, 10'($urandom));
		write_reg(CFG_T0_WINDOW, 10'h3ff);
		cfg_valid <= 1'b0;
		run_random(150);
		settle();

		$display("Run covered %0d words in %0d frames under 4 register settings, %0d reports.",
			words_sent, frames_sent, reports_checked);
		$display("Status codes reported (one bit per code, highest first): %b", status_seen);
		if (fail_count == 0 && reports_pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
